[design/amygdala_associative_learner_unit_macros.svh]
// Assertion macros used by aal_back. Each use sits on a line of its own.
`ifndef AMYGDALA_ASSOCIATIVE_LEARNER_UNIT_MACROS_SVH
`define AMYGDALA_ASSOCIATIVE_LEARNER_UNIT_MACROS_SVH

// Property checked only while the block is out of reset.
`define AAL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define AAL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/aal_pkg.sv]
package aal_pkg;

  localparam int IDX_MAX_W = 8;

  localparam logic signed [15:0] ONE_Q12 = 16'sd4096;
  localparam logic signed [15:0] S16_MAX = 16'sh7fff;
  localparam logic signed [15:0] S16_MIN = 16'sh8000;
  localparam logic [22:0]        S24_POS_MAX = 23'h7fffff;

  typedef struct packed {
    logic signed [15:0]   stim;
    logic signed [15:0]   rew;
    logic signed [15:0]   inh;
    logic                 inh_on;
    logic                 first;
    logic                 last;
    logic [IDX_MAX_W-1:0] idx;
  } item_t;

endpackage

[design/aal_front.sv]
module aal_front import aal_pkg::*; #(
  parameter int STIMULUS_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic        in_tuser,
  input  logic        in_tlast,
  input  logic        q_full,
  output logic        q_push,
  output item_t       q_item
);

  localparam int IDX_W = (STIMULUS_COUNT > 1) ? $clog2(STIMULUS_COUNT) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STIMULUS_COUNT - 1);

  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_nxt;
  logic             last;

  // The tick ends on the flagged element or on the last slot of the array.
  assign last      = in_tlast || (idx_r == LAST_IDX);
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;
  assign idx_nxt   = last ? '0 : idx_r + 1'b1;

  always_comb begin
    q_item.stim   = $signed(in_tdata[15:0]);
    q_item.rew    = $signed(in_tdata[31:16]);
    q_item.inh    = $signed(in_tdata[47:32]);
    q_item.inh_on = in_tuser;
    q_item.first  = (idx_r == '0);
    q_item.last   = last;
    q_item.idx    = IDX_MAX_W'(idx_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (q_push) begin
      idx_r <= idx_nxt;
    end
  end

endmodule

[design/aal_queue.sv]
module aal_queue import aal_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output item_t head,
  output logic  empty
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t              ent_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_nxt;

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = ent_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[design/aal_back.sv]
`include "amygdala_associative_learner_unit_macros.svh"

module aal_back import aal_pkg::*; #(
  parameter int STIMULUS_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        q_empty,
  input  item_t       q_head,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,
  output logic        out_tlast
);

  localparam int IDX_W = (STIMULUS_COUNT > 1) ? $clog2(STIMULUS_COUNT) : 1;
  localparam logic signed [56:0] RND28 = 57'sd134217728;
  localparam logic signed [31:0] RND12 = 32'sd2048;

  typedef enum logic [2:0] {S_IDLE, S_M1, S_M2, S_WUP, S_ACT, S_FIN} state_t;

  function automatic logic signed [23:0] sat24(input logic signed [24:0] x);
    logic signed [23:0] r;
    if (x[24] != x[23]) begin
      r = x[24] ? 24'sh800000 : 24'sh7fffff;
    end else begin
      r = x[23:0];
    end
    return r;
  endfunction

  function automatic logic [22:0] clamp_pos23(input logic signed [24:0] x);
    logic [22:0] r;
    if (x[24]) begin
      r = '0;
    end else if (x[23]) begin
      r = S24_POS_MAX;
    end else begin
      r = x[22:0];
    end
    return r;
  endfunction

  state_t             state_r;
  logic [15:0]        lr_r;
  item_t              cur_r;
  logic [31:0]        mem_r [STIMULUS_COUNT];
  logic [STIMULUS_COUNT-1:0] valid_r;
  logic [31:0]        rd_r;
  logic               vld_r;
  logic [22:0]        adv_r;
  logic signed [15:0] w_old_r;
  logic signed [32:0] p1_r;
  logic signed [56:0] p2_r;
  logic signed [15:0] w_r;
  logic signed [31:0] pa_r;
  logic signed [23:0] sum_r;
  logic signed [23:0] prev_sum_r;
  logic [22:0]        delayed_r;
  logic               out_valid_r;
  logic [15:0]        out_weight_r;
  logic [15:0]        out_act_r;
  logic [12:0]        out_emotion_r;
  logic               out_last_r;

  logic [IDX_W-1:0]   addr_rd;
  logic [IDX_W-1:0]   addr_wr;
  logic               fin_go;
  logic [22:0]        adv_nxt;
  logic signed [15:0] ps_sel;
  logic signed [15:0] w_sel;
  logic signed [32:0] p1_nxt;
  logic signed [56:0] p2_nxt;
  logic signed [56:0] rnd;
  logic signed [28:0] delta;
  logic signed [29:0] wsum;
  logic signed [15:0] w_nxt;
  logic signed [31:0] pa_nxt;
  logic signed [31:0] ract;
  logic signed [19:0] aq;
  logic signed [15:0] act;
  logic signed [23:0] sum_base;
  logic signed [23:0] sum_nxt;
  logic signed [15:0] inh_sel;
  logic [22:0]        delayed_nxt;
  logic [12:0]        emo;

  assign addr_rd = q_head.idx[IDX_W-1:0];
  assign addr_wr = cur_r.idx[IDX_W-1:0];
  assign q_pop   = (state_r == S_IDLE) && !q_empty;
  assign fin_go  = (state_r == S_FIN) && (!out_valid_r || out_tready);

  always_comb begin
    adv_nxt  = clamp_pos23(25'(q_head.rew) - 25'(prev_sum_r));
    ps_sel   = vld_r ? $signed(rd_r[31:16]) : 16'sd0;
    w_sel    = vld_r ? $signed(rd_r[15:0]) : 16'sd0;
    p1_nxt   = $signed({1'b0, lr_r}) * ps_sel;
    p2_nxt   = p1_r * $signed({1'b0, adv_r});
    rnd      = p2_r + RND28;
    delta    = rnd[56:28];
    wsum     = 30'(delta) + 30'(w_old_r);
    if (wsum < 30'(S16_MIN)) begin
      w_nxt = S16_MIN;
    end else if (wsum > 30'(ONE_Q12)) begin
      w_nxt = ONE_Q12;
    end else begin
      w_nxt = wsum[15:0];
    end
    pa_nxt   = cur_r.stim * w_r;
    ract     = pa_r + RND12;
    aq       = ract[31:12];
    if (aq > 20'(S16_MAX)) begin
      act = S16_MAX;
    end else if (aq < 20'(S16_MIN)) begin
      act = S16_MIN;
    end else begin
      act = aq[15:0];
    end
    sum_base    = cur_r.first ? 24'sd0 : sum_r;
    sum_nxt     = sat24(25'(sum_base) + 25'(act));
    inh_sel     = cur_r.inh_on ? cur_r.inh : 16'sd0;
    delayed_nxt = clamp_pos23(25'(prev_sum_r) - 25'(inh_sel));
    emo         = (delayed_r > 23'(ONE_Q12)) ? 13'(ONE_Q12) : delayed_r[12:0];
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      mem_r[addr_wr] <= {cur_r.stim, w_r};
    end
    if (q_pop) begin
      rd_r <= mem_r[addr_rd];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lr_r        <= 16'd6554;
      valid_r     <= '0;
      vld_r       <= 1'b0;
      adv_r       <= '0;
      sum_r       <= '0;
      prev_sum_r  <= '0;
      delayed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        lr_r <= cfg_wr_data;
      end
      if (out_valid_r && out_tready && !fin_go) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            cur_r <= q_head;
            vld_r <= valid_r[addr_rd];
            if (q_head.first) begin
              adv_r <= adv_nxt;
            end
            state_r <= S_M1;
          end
        end
        S_M1: begin
          w_old_r <= w_sel;
          p1_r    <= p1_nxt;
          state_r <= S_M2;
        end
        S_M2: begin
          p2_r    <= p2_nxt;
          state_r <= S_WUP;
        end
        S_WUP: begin
          w_r     <= w_nxt;
          state_r <= S_ACT;
        end
        S_ACT: begin
          pa_r    <= pa_nxt;
          state_r <= S_FIN;
        end
        S_FIN: begin
          if (fin_go) begin
            valid_r[addr_wr] <= 1'b1;
            sum_r            <= sum_nxt;
            out_valid_r      <= 1'b1;
            out_weight_r     <= w_r;
            out_act_r        <= act;
            out_last_r       <= cur_r.last;
            out_emotion_r    <= cur_r.last ? emo : '0;
            if (cur_r.last) begin
              delayed_r  <= delayed_nxt;
              prev_sum_r <= sum_nxt;
            end
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {3'b000, out_emotion_r, out_act_r, out_weight_r};

  `AAL_ASSERT(a_pop_starts_work, q_pop |=> state_r == S_M1, "pop did not start an item")
  `AAL_ASSERT(a_weight_capped, out_valid_r |-> $signed(out_weight_r) <= ONE_Q12, "weight above 1.0")
  `AAL_ASSERT(a_emotion_only_last, out_valid_r && !out_last_r |-> out_emotion_r == '0, "emotion on inner element")
  `AAL_ASSERT(a_emotion_range, out_valid_r |-> out_emotion_r <= 13'(ONE_Q12), "emotion above 1.0")
  `AAL_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> state_r == S_IDLE && !out_valid_r, "reset left work open")

endmodule

[design/amygdala_associative_learner_unit.sv]
// Amygdala associative learner. One tick is streamed as up to STIMULUS_COUNT
// stimulus requests on the in_ channel; in_tlast closes a tick early, and the
// element in the last slot always closes it. Reward is taken from the first
// request of a tick and inhibition from the last one.
// Every request yields exactly one result on the out_ channel, in order. The
// result carries the updated weight and the activation; on the tick's last
// element out_tlast is high and the emotion field holds the delayed emotion.
// The learning rate is written through cfg_wr_en and cfg_wr_data; the user
// must write it only while idle, which the block does not enforce. A request
// is taken into a two-entry queue in the cycle it is offered while the queue is
// not full. The back end handles each request in steps: a weight memory read,
// two multiplies for the weight update, the weight clamp, the activation
// multiply and the final round and sum; it pops a new request only once the
// last is done. Reset clears the weights, the stimulus history, the sums and the
// learning rate to its default, and empties the queue and output register.
// When the receiver holds out_tready low the result stays in the output
// register, the back end waits, and once the queue fills in_tready drops.
module amygdala_associative_learner_unit import aal_pkg::*; #(
  parameter int STIMULUS_COUNT = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // stimulus, reward, inhibition
  input  logic        in_tuser,   // inhibition_present
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // weight, activation, emotion, zero pad
  output logic        out_tlast
);

  logic  q_full;
  logic  q_push;
  item_t q_item;
  logic  q_empty;
  logic  q_pop;
  item_t q_head;

  aal_front #(
    .STIMULUS_COUNT(STIMULUS_COUNT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (q_item)
  );

  aal_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  aal_back #(
    .STIMULUS_COUNT(STIMULUS_COUNT)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule
